// ----- hw/rtl/fbpa_pkg.sv -----
package fbpa_pkg;

  localparam int unsigned DividendW = 32;
  localparam int unsigned DivisorW  = 16;
  localparam int unsigned StepCntW  = $clog2(DividendW);

endpackage

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// Fixed-size block pool allocator with a free-list link table.
// Commands arrive on start, op_i and block_address_i and are taken at a rising
// edge where start is high and busy is low. Each command gives one result beat:
// status_o, granted_address_o, bytes_allocated_o and pool_empty_o are valid for
// exactly the one cycle in which result_valid_o is high, and the receiver has
// no means to hold them off. A new command may be taken in that same cycle.
// Allocate makes a registered read of the link table and the index times block
// size product, then the address add. With the pool empty it answers at once
// with the empty status. Free waits on
// the one-bit-per-cycle restoring divider that turns the offset into a block
// index; an address below the base is refused without the divider. Clear writes
// n link table entries, one per cycle, where n is blocks_in_pool clamped to
// 1..MAX_BLOCKS. Unknown op codes answer at once and change nothing.
// The result strobe is registered and rises in the cycle after the command's last step.
// The registers sit on an APB port at byte addresses 0, 4 and 8. The user must
// write them only while the block is idle; the block itself does not enforce it.
// After reset it runs clear's chaining pass over min(256, MAX_BLOCKS) entries,
// with busy high and no result beat; register writes are taken during it.
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS    = 256,
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [31:0] block_address_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] granted_address_o,
  output logic [23:0] bytes_allocated_o,
  output logic        pool_empty_o
);

  localparam int unsigned IdxW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned LinkW = IdxW + 1;
  localparam logic [LinkW-1:0] EndCode = LinkW'(MAX_BLOCKS);
  localparam logic [LinkW-1:0] ResetActive = LinkW'((MAX_BLOCKS < 256) ? MAX_BLOCKS : 256);
  localparam logic [31:0] GrantMask =
    (ADDRESS_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDRESS_WIDTH) - 64'd1);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_BYTES  = 2'd1;
  localparam logic [1:0] REG_BLOCKS = 2'd2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [31:0]      base_q;
  logic [15:0]      bsz_q;
  logic [8:0]       bip_q;
  logic             cfg_we;

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic             list_end_q, list_end_d;
  logic [23:0]      total_q, total_d;
  logic [LinkW-1:0] active_q, active_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic             report_q, report_d;
  logic             rv_q, rv_d;
  logic [1:0]       status_q, status_d;
  logic [31:0]      granted_q, granted_d;

  logic [LinkW-1:0] link_mem [MAX_BLOCKS];
  logic [LinkW-1:0] rd_q;
  logic [31:0]      prod_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_wa;
  logic [LinkW-1:0] mem_wd;

  logic [15:0]      bsz_eff;
  logic [31:0]      clamp_w;
  logic [24:0]      tot_add;
  logic [23:0]      tot_inc;
  logic [23:0]      tot_dec;
  logic [32:0]      grant_sum;
  logic [LinkW-1:0] cnt_next;
  logic             div_start;
  logic             div_done;
  logic [31:0]      quotient;
  logic             accept;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
      bsz_q  <= 16'd64;
      bip_q  <= 9'd256;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_BASE:   base_q <= pwdata;
        REG_BYTES:  bsz_q  <= pwdata[15:0];
        REG_BLOCKS: bip_q  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BASE:   prdata = base_q;
      REG_BYTES:  prdata = {16'd0, bsz_q};
      REG_BLOCKS: prdata = {23'd0, bip_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign bsz_eff = (bsz_q == 16'd0) ? 16'd1 : bsz_q;

  always_comb begin
    if (bip_q == 9'd0) begin
      clamp_w = 32'd1;
    end else if (32'(bip_q) > MAX_BLOCKS) begin
      clamp_w = 32'(MAX_BLOCKS);
    end else begin
      clamp_w = 32'(bip_q);
    end
  end

  assign tot_add   = {1'b0, total_q} + 25'(bsz_eff);
  assign tot_inc   = tot_add[24] ? 24'hFF_FFFF : tot_add[23:0];
  assign tot_dec   = (total_q < 24'(bsz_eff)) ? 24'd0 : total_q - 24'(bsz_eff);
  assign grant_sum = {1'b0, base_q} + {1'b0, prod_q};
  assign cnt_next  = LinkW'(cnt_q) + LinkW'(1);
  assign busy      = state_q != S_IDLE;
  assign accept    = start && !busy;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    list_end_d = list_end_q;
    total_d    = total_q;
    active_d   = active_q;
    cnt_d      = cnt_q;
    report_d   = report_q;
    rv_d       = 1'b0;
    status_d   = status_q;
    granted_d  = granted_q;
    mem_we     = 1'b0;
    mem_wa     = cnt_q;
    mem_wd     = cnt_next;
    div_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d  = STATUS_OK;
          granted_d = 32'd0;
          case (op_i)
            OP_ALLOC: begin
              if (list_end_q) begin
                status_d = STATUS_EMPTY;
                rv_d     = 1'b1;
              end else begin
                state_d = S_ALLOC;
              end
            end
            OP_FREE: begin
              if (block_address_i < base_q) begin
                status_d = STATUS_RANGE;
                rv_d     = 1'b1;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            OP_CLEAR: begin
              active_d = clamp_w[LinkW-1:0];
              cnt_d    = '0;
              report_d = 1'b1;
              state_d  = S_CLEAR;
            end
            default: begin
              rv_d = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        granted_d = grant_sum[31:0] & GrantMask;
        total_d   = tot_inc;
        if (rd_q >= EndCode) begin
          list_end_d = 1'b1;
        end else begin
          head_d = rd_q[IdxW-1:0];
        end
        rv_d    = 1'b1;
        state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          if (quotient < 32'(active_q)) begin
            mem_we     = 1'b1;
            mem_wa     = quotient[IdxW-1:0];
            mem_wd     = list_end_q ? EndCode : LinkW'(head_q);
            head_d     = quotient[IdxW-1:0];
            list_end_d = 1'b0;
            total_d    = tot_dec;
          end else begin
            status_d = STATUS_RANGE;
          end
          rv_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_next == active_q) begin
          mem_wd     = EndCode;
          head_d     = '0;
          list_end_d = 1'b0;
          total_d    = 24'd0;
          rv_d       = report_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      head_q     <= '0;
      list_end_q <= 1'b0;
      total_q    <= 24'd0;
      active_q   <= ResetActive;
      cnt_q      <= '0;
      report_q   <= 1'b0;
      rv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      list_end_q <= list_end_d;
      total_q    <= total_d;
      active_q   <= active_d;
      cnt_q      <= cnt_d;
      report_q   <= report_d;
      rv_q       <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    granted_q <= granted_d;
    prod_q    <= 32'(head_q) * 32'(bsz_eff);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    rd_q <= link_mem[head_q];
  end

  fbpa_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (block_address_i - base_q),
    .divisor_i  (bsz_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign result_valid_o    = rv_q;
  assign status_o          = status_q;
  assign granted_address_o = granted_q;
  assign bytes_allocated_o = total_q;
  assign pool_empty_o      = list_end_q;

`ifndef SYNTHESIS
  a_head_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!list_end_q && state_q != S_CLEAR) |-> (LinkW'(head_q) < active_q))
    else $error("Free list head lies outside the active pool.");
  a_alloc_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_ALLOC && !list_end_q) |=> state_q == S_ALLOC)
    else $error("Allocate with free blocks did not read the link table.");
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && status_q == STATUS_EMPTY) |-> list_end_q)
    else $error("Pool empty reported while blocks remain.");
  a_no_grant_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && status_q != STATUS_OK) |-> granted_q == 32'd0)
    else $error("Address granted on a failed command.");
`endif

endmodule

// ----- hw/rtl/fbpa_serial_div.sv -----
module fbpa_serial_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [fbpa_pkg::DividendW-1:0]       dividend_i,
  input  logic [fbpa_pkg::DivisorW-1:0]        divisor_i,
  output logic                                 done_o,
  output logic [fbpa_pkg::DividendW-1:0]       quotient_o
);

  localparam logic [fbpa_pkg::StepCntW-1:0] LastStep = fbpa_pkg::StepCntW'(fbpa_pkg::DividendW - 1);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [fbpa_pkg::StepCntW-1:0]     cnt_q, cnt_d;
  logic [fbpa_pkg::DivisorW-1:0]     div_q, div_d;
  logic [fbpa_pkg::DivisorW-1:0]     rem_q, rem_d;
  logic [fbpa_pkg::DividendW-1:0]    quo_q, quo_d;
  logic [fbpa_pkg::DivisorW:0]       rem_sh;
  logic [fbpa_pkg::DivisorW:0]       rem_sub;
  logic                              fits;

  assign rem_sh  = {rem_q, quo_q[fbpa_pkg::DividendW-1]};
  assign fits    = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[fbpa_pkg::DivisorW-1:0] : rem_sh[fbpa_pkg::DivisorW-1:0];
      quo_d = {quo_q[fbpa_pkg::DividendW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("Divider started while busy.");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("Divider done held longer than one cycle.");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == LastStep) |=> done_q)
    else $error("Divider did not finish after its last step.");
`endif

endmodule
